// File: design/eqbs_pkg.sv
// ----------------------------------------------------------------------------
// eqbs_pkg
// Shared types and constants for the event queued buzzer sequencer.
// ----------------------------------------------------------------------------
package eqbs_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int TICKS_W   = 16;
	localparam int EV_W      = 4;
	localparam int DROP_W    = 32;

	typedef logic [TICKS_W-1:0] ticks_t;
	typedef logic [EV_W-1:0]    ev_t;
	typedef logic [1:0]         phase_t;

	// item kinds
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// event codes
	localparam ev_t EV_NONE   = 4'd0;
	localparam ev_t EV_BOOT   = 4'd1;
	localparam ev_t EV_LOCKED = 4'd7;
	localparam ev_t EV_ALIGN  = 4'd8;

	// duration register indexes
	localparam logic [REG_IDX_W-1:0] REG_LOCKED      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ALIGN_PULSE = 3'd7;

	// align pattern phases
	localparam phase_t PH_FIRST  = 2'd0;
	localparam phase_t PH_GAP    = 2'd1;
	localparam phase_t PH_SECOND = 2'd2;

	localparam ticks_t DUR_RESET [NUM_REGS] = '{
		16'd40, 16'd10, 16'd20, 16'd20, 16'd60, 16'd10, 16'd100, 16'd12
	};

	typedef struct packed {
		ev_t    ev;
		phase_t phase;
		ticks_t ticks;
		logic   level;
	} seq_t;

	// load a tone; a zero duration leaves the sequencer idle
	function automatic seq_t start_ev(input ev_t ev, input ticks_t dur);
		seq_t s;
		s.ev    = ev;
		s.phase = PH_FIRST;
		s.ticks = dur;
		s.level = 1'b1;
		if (dur == '0) begin
			s.ev    = EV_NONE;
			s.level = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: design/event_queued_buzzer_sequencer_top.sv
// ----------------------------------------------------------------------------
// event_queued_buzzer_sequencer_top
// Buzzer event sequencer: event queue, urgent locked tone, align pattern.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one beat per item: operation
//  0 is a time tick that runs the sequencer, operation 1 is an event request
//  with its code on event_req. Output channel (out_valid / out_stall) returns
//  exactly one beat per input beat: accepted flag, buzzer pin level, event
//  now playing and the running drop count.
//  Path: a taken beat is held in the input register; its result is written
//  to the output register once the output register can take it.
//  Throughput: one beat per cycle; the whole update is a single pass of
//  small logic (one 16-bit decrement, the queue pointers, the drop counter)
//  between the input register and the output register.
//  Stall: while the output beat is stalled the input register holds and
//  in_stall is raised once it is full, so nothing is lost or repeated.
//  Reset: queue empty, sequencer idle, drop count zero, durations back to
//  their defaults. Durations are set through the APB port, 16 bits each at
//  byte address 4*index; write them only while the block is idle.
// ----------------------------------------------------------------------------
module event_queued_buzzer_sequencer_top #(
	parameter int QUEUE_DEPTH     = 8,
	parameter int ALIGN_GAP_TICKS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request / tick channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  eqbs_pkg::ev_t             event_req,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic                      pin_active,
	output eqbs_pkg::ev_t             current_event,
	output logic [eqbs_pkg::DROP_W-1:0] drop_total,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [eqbs_pkg::PADDR_W-1:0] paddr,
	input  logic [eqbs_pkg::PDATA_W-1:0] pwdata,
	output logic [eqbs_pkg::PDATA_W-1:0] prdata,
	output logic                      pready
);
	import eqbs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam ticks_t GAP = TICKS_W'(ALIGN_GAP_TICKS);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic ticks_t dur_of(input ticks_t regs [NUM_REGS], input ev_t ev);
		ticks_t d;
		d = '0;
		if (ev >= EV_BOOT && ev <= EV_ALIGN)
			d = regs[REG_IDX_W'(ev - 1'b1)];
		return d;
	endfunction

	// duration registers
	ticks_t dur_q [NUM_REGS];
	logic   cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign prdata  = {{(PDATA_W - TICKS_W){1'b0}}, dur_q[cfg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				dur_q[i] <= DUR_RESET[i];
		end else if (cfg_wr) begin
			dur_q[cfg_idx] <= pwdata[TICKS_W-1:0];
		end
	end

	// input register
	logic valid_s1;
	logic op_s1;
	ev_t  ev_s1;
	logic advance;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= operation;
			ev_s1 <= event_req;
		end
	end

	// sequencer state
	seq_t              seq_q;
	logic              urgent_q;
	logic [PTR_W-1:0]  rd_q;
	logic [PTR_W-1:0]  wr_q;
	logic [DROP_W-1:0] drop_q;
	ev_t               fifo_mem [QUEUE_DEPTH];
	ev_t               head_q;

	seq_t              nxt_seq;
	logic              nxt_urgent;
	logic [PTR_W-1:0]  nxt_rd;
	logic [PTR_W-1:0]  nxt_wr;
	logic [PTR_W-1:0]  wr_inc;
	logic [PTR_W-1:0]  rd_d;
	logic [DROP_W-1:0] nxt_drop;
	ticks_t            cnt;
	logic              acc;
	logic              wr_en;
	logic              pop_ok;

	always_comb begin
		nxt_seq    = seq_q;
		nxt_urgent = urgent_q;
		nxt_rd     = rd_q;
		nxt_wr     = wr_q;
		nxt_drop   = drop_q;
		acc        = 1'b0;
		wr_en      = 1'b0;
		pop_ok     = 1'b0;
		wr_inc     = ptr_next(wr_q);
		cnt        = seq_q.ticks - 1'b1;
		if (op_s1 == OP_REQUEST) begin
			if (ev_s1 >= EV_BOOT && ev_s1 <= EV_ALIGN) begin
				priority if (ev_s1 == EV_LOCKED) begin
					nxt_urgent = 1'b1;
					acc        = 1'b1;
				end else if (wr_inc == rd_q) begin
					nxt_drop = drop_q + 1'b1;
				end else begin
					wr_en  = 1'b1;
					nxt_wr = wr_inc;
					acc    = 1'b1;
				end
			end
		end else if (urgent_q) begin
			// flush queue and start the locked tone
			nxt_urgent = 1'b0;
			nxt_rd     = wr_q;
			nxt_seq    = start_ev(EV_LOCKED, dur_q[REG_LOCKED]);
		end else begin
			pop_ok = 1'b1;
			if (seq_q.ticks != '0) begin
				nxt_seq.ticks = cnt;
				priority if (cnt != '0) begin
					pop_ok = 1'b0;
				end else if (seq_q.ev == EV_ALIGN && seq_q.phase == PH_FIRST
						&& GAP != '0) begin
					nxt_seq.level = 1'b0;
					nxt_seq.phase = PH_GAP;
					nxt_seq.ticks = GAP;
					pop_ok        = 1'b0;
				end else if (seq_q.ev == EV_ALIGN && seq_q.phase == PH_GAP
						&& dur_q[REG_ALIGN_PULSE] != '0) begin
					nxt_seq.level = 1'b1;
					nxt_seq.phase = PH_SECOND;
					nxt_seq.ticks = dur_q[REG_ALIGN_PULSE];
					pop_ok        = 1'b0;
				end else begin
					nxt_seq.ev    = EV_NONE;
					nxt_seq.phase = PH_FIRST;
					nxt_seq.level = 1'b0;
				end
			end
			if (pop_ok && nxt_seq.ev == EV_NONE && rd_q != wr_q) begin
				nxt_rd  = ptr_next(rd_q);
				nxt_seq = start_ev(head_q, dur_of(dur_q, head_q));
			end
		end
	end

	assign rd_d = advance ? nxt_rd : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			urgent_q <= 1'b0;
			rd_q     <= '0;
			wr_q     <= '0;
			drop_q   <= '0;
		end else if (advance) begin
			seq_q    <= nxt_seq;
			urgent_q <= nxt_urgent;
			rd_q     <= nxt_rd;
			wr_q     <= nxt_wr;
			drop_q   <= nxt_drop;
		end
	end

	// queue storage; head_q holds the entry at the next read pointer,
	// with a bypass for a write landing on that slot
	always_ff @(posedge clk) begin
		if (advance && wr_en)
			fifo_mem[wr_q] <= ev_s1;
		if (advance && wr_en && wr_q == rd_d)
			head_q <= ev_s1;
		else
			head_q <= fifo_mem[rd_d];
	end

	// result register
	logic out_valid_q;
	logic accepted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			accepted_q <= acc;
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign pin_active    = seq_q.level;
	assign current_event = seq_q.ev;
	assign drop_total    = drop_q;

	// checks
	a_pin_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.level |-> seq_q.ev != EV_NONE)
		else $error("buzzer driven with no event playing");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.ev == EV_NONE |-> (seq_q.ticks == '0 && seq_q.phase == PH_FIRST))
		else $error("idle sequencer holds a count or phase");

	a_phase_align_only: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.phase != PH_FIRST |-> seq_q.ev == EV_ALIGN)
		else $error("pattern phase set on a plain tone");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q != $past(drop_q) |-> drop_q == $past(drop_q) + 1'b1)
		else $error("drop count moved by more than one");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> ($stable(seq_q) && $stable(rd_q) && $stable(wr_q)))
		else $error("sequencer state changed without an item");

endmodule

// File: sim/buzzer_check_pkg.sv
// ----------------------------------------------------------------------------
// buzzer_check_pkg
// Result prediction and checking for the buzzer event sequencer bench.
// ----------------------------------------------------------------------------
package buzzer_check_pkg;

	import eqbs_pkg::*;

	localparam int QUEUE_DEPTH = 8;
	localparam int GAP_TICKS   = 12;

	// event codes not named in the design package
	localparam ev_t EV_COMMAND = 4'd2;
	localparam ev_t EV_PREPARE = 4'd3;
	localparam ev_t EV_BAD_LOW = 4'd9;
	localparam ev_t EV_BAD_TOP = 4'd15;

	// duration register indexes not named in the design package
	localparam int REG_BOOT    = 0;
	localparam int REG_COMMAND = 1;

	typedef struct packed {
		logic              acc;
		logic              pin;
		ev_t               ev;
		logic [DROP_W-1:0] drops;
	} beat_t;

	function automatic bit is_event_code(input ev_t code);
		return code >= EV_BOOT && code <= EV_ALIGN;
	endfunction

	class buzzer_scoreboard;
		ticks_t            dur [NUM_REGS];
		ev_t               slots [QUEUE_DEPTH];
		int unsigned       wr_idx;
		int unsigned       rd_idx;
		bit                urgent;
		ev_t               playing;
		phase_t            phase;
		ticks_t            left;
		logic [DROP_W-1:0] drops;
		logic              level;
		beat_t             pending_q [$];
		int unsigned       mismatches;

		function new();
			foreach (dur[i]) dur[i] = DUR_RESET[i];
			foreach (slots[i]) slots[i] = EV_NONE;
			wr_idx     = 0;
			rd_idx     = 0;
			urgent     = 1'b0;
			playing    = EV_NONE;
			phase      = PH_FIRST;
			left       = '0;
			drops      = '0;
			level      = 1'b0;
			mismatches = 0;
		endfunction

		function void set_duration(input int unsigned idx, input ticks_t val);
			if (idx < NUM_REGS)
				dur[idx] = val;
		endfunction

		function int unsigned bump(input int unsigned p);
			return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
		endfunction

		// zero duration: skipped, stays idle
		function void load_tone(input ev_t code);
			playing = code;
			phase   = PH_FIRST;
			left    = dur[int'(code) - 1];
			level   = 1'b1;
			if (left == '0) begin
				playing = EV_NONE;
				level   = 1'b0;
			end
		endfunction

		// advance the model by one accepted beat and queue the expected result
		function void note_input(input logic op, input ev_t code);
			beat_t want;
			logic  acc;
			bit    busy;
			ev_t   nxt;
			acc = 1'b0;
			if (op == OP_REQUEST) begin
				if (is_event_code(code)) begin
					if (code == EV_LOCKED) begin
						urgent = 1'b1;
						acc    = 1'b1;
					end else if (bump(wr_idx) == rd_idx) begin
						drops = drops + 1'b1;
					end else begin
						slots[wr_idx] = code;
						wr_idx        = bump(wr_idx);
						acc           = 1'b1;
					end
				end
			end else if (urgent) begin
				urgent = 1'b0;
				rd_idx = wr_idx;
				load_tone(EV_LOCKED);
			end else begin
				busy = 1'b0;
				if (left != '0) begin
					left = left - 16'd1;
					if (left != '0) begin
						busy = 1'b1;
					end else if (playing == EV_ALIGN && phase == PH_FIRST && GAP_TICKS != 0) begin
						level = 1'b0;
						phase = PH_GAP;
						left  = ticks_t'(GAP_TICKS);
						busy  = 1'b1;
					end else if (playing == EV_ALIGN && phase == PH_GAP &&
							dur[REG_ALIGN_PULSE] != '0) begin
						level = 1'b1;
						phase = PH_SECOND;
						left  = dur[REG_ALIGN_PULSE];
						busy  = 1'b1;
					end else begin
						level   = 1'b0;
						playing = EV_NONE;
						phase   = PH_FIRST;
					end
				end
				if (!busy && playing == EV_NONE && rd_idx != wr_idx) begin
					nxt    = slots[rd_idx];
					rd_idx = bump(rd_idx);
					load_tone(nxt);
				end
			end
			want.acc   = acc;
			want.pin   = level;
			want.ev    = playing;
			want.drops = drops;
			pending_q.push_back(want);
		endfunction

		task flag_mismatch(input string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		task check_result(input beat_t got);
			beat_t want;
			if (pending_q.size() == 0) begin
				flag_mismatch($sformatf("result beat with nothing expected: acc=%0b pin=%0b ev=%0d drops=%0d",
					got.acc, got.pin, got.ev, got.drops));
				return;
			end
			want = pending_q.pop_front();
			if (got.acc !== want.acc)
				flag_mismatch($sformatf("accepted got %0b want %0b", got.acc, want.acc));
			if (got.pin !== want.pin)
				flag_mismatch($sformatf("pin_active got %0b want %0b", got.pin, want.pin));
			if (got.ev !== want.ev)
				flag_mismatch($sformatf("current_event got %0d want %0d", got.ev, want.ev));
			if (got.drops !== want.drops)
				flag_mismatch($sformatf("drop_total got %0d want %0d", got.drops, want.drops));
		endtask
	endclass

endpackage

// File: sim/event_queued_buzzer_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// event_queued_buzzer_sequencer_top_tb
// Drives tick and request beats into the buzzer sequencer under random
// source gaps and sink stalls, predicts every result beat in a scoreboard
// and compares field by field. Durations are reprogrammed between phases.
// ----------------------------------------------------------------------------
module event_queued_buzzer_sequencer_top_tb;

	import eqbs_pkg::*;
	import buzzer_check_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int DRAIN_CYCLES     = 4;     // margin to let the pipe empty
	localparam int RANDOM_PER_PHASE = 215;
	localparam int NUM_PHASES       = 6;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                operation = OP_TICK;
	ev_t                 event_req = EV_NONE;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                accepted;
	logic                pin_active;
	ev_t                 current_event;
	logic [DROP_W-1:0]   drop_total;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	buzzer_scoreboard sb = new();

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned cycles       = 0;

	event_queued_buzzer_sequencer_top #(
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.ALIGN_GAP_TICKS (GAP_TICKS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.event_req     (event_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.pin_active    (pin_active),
		.current_event (current_event),
		.drop_total    (drop_total),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("event_queued_buzzer_sequencer_top_tb NOT OK");
			$finish;
		end
	end

	// sink side: random stall, independent of anything the block does
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	// output monitor; handshake sampled with pre-edge values
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result({accepted, pin_active, current_event, drop_total});
	end

	// One input beat. valid is dropped here only inside the gap loop, so a
	// back-to-back beat never lowers and raises it in the same step.
	task automatic push_item(input logic op, input ev_t code);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		event_req <= code;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, code);
	endtask

	// APB write: setup, access, then bus idle
	task automatic write_reg(input int unsigned idx, input ticks_t val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * idx);
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		sb.set_duration(idx, val);
	endtask

	// wait until every expected beat has come back, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly short tones so queued events drain; sometimes zero or the max
	function automatic ticks_t pick_ticks();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) return '0;
		if (r < 75) return ticks_t'($urandom_range(1, 6));
		if (r < 95) return ticks_t'($urandom_range(7, 30));
		return '1;
	endfunction

	// Bursts of requests followed by runs of ticks, plus some pure noise.
	// Requests with no valid event code do not count toward n.
	task automatic run_random(input int unsigned n);
		int unsigned done_items;
		int unsigned r;
		int unsigned burst;
		ev_t         code;
		done_items = 0;
		while (done_items < n) begin
			r = $urandom_range(99);
			if (r < 10) begin
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					code = ev_t'($urandom_range(15));
					if ($urandom_range(1)) begin
						push_item(OP_REQUEST, code);
						if (is_event_code(code))
							done_items++;
					end else begin
						push_item(OP_TICK, code);
						done_items++;
					end
				end
			end else begin
				burst = $urandom_range(0, 4);
				repeat (burst) begin
					r = $urandom_range(99);
					if (r < 6)
						code = $urandom_range(1) ? EV_NONE : ev_t'($urandom_range(9, 15));
					else if (r < 16)
						code = EV_LOCKED;
					else begin
						code = ev_t'($urandom_range(1, 7));
						if (code == EV_LOCKED)
							code = EV_ALIGN;
					end
					push_item(OP_REQUEST, code);
					if (is_event_code(code))
						done_items++;
				end
				burst = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
				repeat (burst) begin
					push_item(OP_TICK, ev_t'($urandom_range(15)));
					done_items++;
				end
			end
		end
	endtask

	initial begin
		src_idle_pct = 23;
		snk_idle_pct = 81;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refused codes at both ends and just past the top
		push_item(OP_REQUEST, EV_NONE);
		push_item(OP_REQUEST, EV_BAD_TOP);
		push_item(OP_REQUEST, EV_BAD_LOW);
		// fill the queue: it holds depth - 1, the next request is dropped
		for (int e = 1; e <= 8; e++) begin
			if (ev_t'(e) != EV_LOCKED)
				push_item(OP_REQUEST, ev_t'(e));
		end
		push_item(OP_REQUEST, EV_COMMAND);
		// locked twice before a tick, then the tick flushes the queue
		push_item(OP_REQUEST, EV_LOCKED);
		push_item(OP_REQUEST, EV_LOCKED);
		push_item(OP_TICK, EV_BAD_TOP);
		push_item(OP_TICK, EV_NONE);
		settle();

		// urgent with a zero duration: flush, go idle, pop nothing
		write_reg(REG_LOCKED, '0);
		write_reg(REG_ALIGN_PULSE, 16'd2);
		write_reg(REG_BOOT, 16'd1);
		push_item(OP_REQUEST, EV_PREPARE);
		push_item(OP_REQUEST, EV_LOCKED);
		push_item(OP_TICK, EV_NONE);
		push_item(OP_TICK, EV_NONE);
		// align into its gap, then zero the pulse so the second stage is empty
		push_item(OP_REQUEST, EV_ALIGN);
		push_item(OP_REQUEST, EV_BOOT);
		repeat (3) push_item(OP_TICK, EV_NONE);
		settle();
		write_reg(REG_ALIGN_PULSE, '0);
		// the gap ends, align finishes and boot starts on the same tick
		repeat (GAP_TICKS + 1) push_item(OP_TICK, EV_NONE);
		settle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0, 1: begin
					src_idle_pct = 23;
					snk_idle_pct = 81;
				end
				2, 3: begin
					src_idle_pct = 81;
					snk_idle_pct = 23;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int r = 0; r < NUM_REGS; r++)
				write_reg(r, pick_ticks());
			case (ph)
				1: begin
					write_reg(REG_BOOT, '1);
					write_reg(REG_ALIGN_PULSE, '0);
				end
				3: begin
					write_reg(REG_LOCKED, '0);
					write_reg(REG_COMMAND, 16'd1);
				end
				default: ;
			endcase
			run_random(RANDOM_PER_PHASE);
			settle();
		end

		if (sb.pending_q.size() != 0)
			sb.flag_mismatch($sformatf("%0d result beats never arrived", sb.pending_q.size()));
		if (sb.mismatches == 0)
			$display("event_queued_buzzer_sequencer_top_tb OK");
		else
			$display("event_queued_buzzer_sequencer_top_tb NOT OK");
		$finish;
	end

endmodule
